// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the transcoder RTL.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CTRE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define CTRE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ctre_pkg.sv =====
// Shared types, codes and helpers of the charset transcoder.
// No dependencies.
package ctre_pkg;

  localparam int CODE_COUNT = 256;
  localparam int CODE_W     = 8;
  localparam int RESULT_CAP = 16;
  localparam int RAW_MAX    = 4;
  localparam int RAW_CNT_W  = $clog2(RAW_MAX + 1);

  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] STRIP_MASK = 8'h7F;

  // conversion_mode codes; the unused code behaves as plain
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_RTF   = 2'd1;
  localparam logic [1:0] MODE_STRIP = 2'd2;

  typedef enum logic [1:0] {
    REQ_DATA    = 2'd0,
    REQ_WR_CHAR = 2'd1,
    REQ_WR_LEN  = 2'd2,
    REQ_EOS     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BSLASH = 2'd1,
    PH_QUOTE  = 2'd2,
    PH_HIGH   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENTRY,
    ST_RAW
  } ctl_state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ENTRY,
    ACT_RAW
  } act_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic emit_entry;
    logic emit_raw;
  } ctre_cmd_t;

  typedef struct packed {
    logic in_valid;
    act_t act;
    logic len_zero;
    logic entry_last;
    logic raw_last;
    logic out_free;
  } ctre_sts_t;

  // {valid, value} of an ASCII hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ctre_stream_if.sv =====
// Valid/ready channel interfaces of the charset transcoder.
// No dependencies.
interface ctre_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] byte_value;
  logic [7:0] entry_index;
  logic [3:0] char_pos;
  logic [4:0] entry_length;

  modport source (output valid, req_type, byte_value, entry_index, char_pos, entry_length,
                  input ready);
  modport sink (input valid, req_type, byte_value, entry_index, char_pos, entry_length,
                output ready);
endinterface

interface ctre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// ===== hw/rtl/ctre_datapath.sv =====
// Datapath: mode register, escape parser, table memories, raw byte queue, output register.
// Depends on ctre_pkg and ctre_stream_if.
module ctre_datapath import ctre_pkg::*; #(
  parameter int MAX_STR = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_wdata,
  ctre_in_if.sink          in_item,
  ctre_out_if.source       out_res,
  input  ctre_cmd_t        cmd,
  output ctre_sts_t        sts
);

  localparam int PW       = (MAX_STR > 1) ? $clog2(MAX_STR) : 1;
  localparam int LEN_W    = $clog2(MAX_STR + 1);
  localparam int EMIT_MAX = (MAX_STR < RESULT_CAP) ? MAX_STR : RESULT_CAP;
  localparam int ADDR_W   = CODE_W + PW;
  localparam int DEPTH    = CODE_COUNT * (2 ** PW);

  logic [1:0]                  mode_r;
  phase_t                      phase_r, phase_nxt;
  logic [7:0]                  held_r, held_nxt;

  logic [7:0]                  char_mem [DEPTH];
  logic [LEN_W-1:0]            len_mem [CODE_COUNT];
  logic [CODE_COUNT-1:0]       len_vld_r;
  logic [7:0]                  char_q_r;
  logic [LEN_W-1:0]            len_q_r;
  logic                        len_vld_q_r;

  logic [CODE_W-1:0]           code_r, code_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;
  logic [RAW_MAX-1:0][7:0]     raw_r, raw_nxt;
  logic [RAW_CNT_W-1:0]        raw_cnt_r, raw_cnt_nxt;

  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;

  req_t                        req;
  logic [7:0]                  b;
  logic [4:0]                  hi, lo;
  act_t                        dec_act;
  logic [CODE_W-1:0]           dec_code;
  logic [RAW_MAX-1:0][7:0]     dec_raw;
  logic [RAW_CNT_W-1:0]        dec_cnt;
  logic                        pos_ok;
  logic [LEN_W-1:0]            sat_len, len_v, eff_len;
  logic [ADDR_W-1:0]           wr_addr, rd_addr;
  logic                        load_out;

  assign req     = req_t'(in_item.req_type);
  assign b       = in_item.byte_value;
  assign hi      = hex_decode(held_r);
  assign lo      = hex_decode(b);
  assign pos_ok  = 32'(in_item.char_pos) < 32'(MAX_STR);
  assign sat_len = (32'(in_item.entry_length) > 32'(MAX_STR)) ? LEN_W'(MAX_STR)
                                                               : LEN_W'(in_item.entry_length);
  assign wr_addr = {in_item.entry_index, PW'(in_item.char_pos)};

  // decode the offered word against parser state and mode
  always_comb begin
    dec_act   = ACT_NONE;
    dec_code  = b;
    dec_raw   = '0;
    dec_cnt   = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    case (req)
      REQ_DATA: begin
        if (mode_r == MODE_RTF) begin
          case (phase_r)
            PH_IDLE: begin
              if (b == CH_BSLASH) begin
                phase_nxt = PH_BSLASH;
              end else begin
                dec_act = ACT_ENTRY;
              end
            end
            PH_BSLASH: begin
              if (b == CH_QUOTE) begin
                phase_nxt = PH_QUOTE;
              end else begin
                dec_raw[0] = CH_BSLASH;
                dec_raw[1] = b;
                dec_cnt    = RAW_CNT_W'(2);
                phase_nxt  = PH_IDLE;
              end
            end
            PH_QUOTE: begin
              held_nxt  = b;
              phase_nxt = PH_HIGH;
            end
            default: begin
              if (hi[4] && lo[4]) begin
                dec_act  = ACT_ENTRY;
                dec_code = {hi[3:0], lo[3:0]};
              end else begin
                dec_raw[0] = CH_BSLASH;
                dec_raw[1] = CH_QUOTE;
                dec_raw[2] = held_r;
                dec_raw[3] = b;
                dec_cnt    = RAW_CNT_W'(4);
              end
              held_nxt  = '0;
              phase_nxt = PH_IDLE;
            end
          endcase
        end else if (mode_r == MODE_STRIP) begin
          dec_raw[0] = b & STRIP_MASK;
          dec_cnt    = RAW_CNT_W'(1);
        end else begin
          dec_act = ACT_ENTRY;
        end
      end
      REQ_EOS: begin
        dec_raw[0] = CH_BSLASH;
        dec_raw[1] = CH_QUOTE;
        dec_raw[2] = held_r;
        dec_cnt    = RAW_CNT_W'(phase_r);
        phase_nxt  = PH_IDLE;
        held_nxt   = '0;
      end
      default: begin
      end
    endcase
    if (dec_cnt != '0) begin
      dec_act = ACT_RAW;
    end
  end

  assign code_nxt = cmd.accept ? dec_code : code_r;
  assign pos_nxt  = cmd.accept ? '0 : (cmd.emit_entry ? pos_r + PW'(1) : pos_r);
  assign rd_addr  = {code_nxt, pos_nxt};

  always_comb begin
    raw_nxt     = raw_r;
    raw_cnt_nxt = raw_cnt_r;
    if (cmd.accept) begin
      raw_nxt     = dec_raw;
      raw_cnt_nxt = dec_cnt;
    end else if (cmd.emit_raw) begin
      raw_nxt     = {8'h00, raw_r[RAW_MAX-1:1]};
      raw_cnt_nxt = raw_cnt_r - RAW_CNT_W'(1);
    end
  end

  // unwritten length entries read as empty; clip at the per-word result cap
  assign len_v   = len_vld_q_r ? len_q_r : '0;
  assign eff_len = (len_v > LEN_W'(EMIT_MAX)) ? LEN_W'(EMIT_MAX) : len_v;

  assign load_out = cmd.emit_entry | cmd.emit_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_PLAIN;
      phase_r     <= PH_IDLE;
      held_r      <= '0;
      len_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        if (req == REQ_WR_LEN) begin
          len_vld_r[in_item.entry_index] <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r    <= code_nxt;
    pos_r     <= pos_nxt;
    raw_r     <= raw_nxt;
    raw_cnt_r <= raw_cnt_nxt;
    if (load_out) begin
      out_byte_r <= cmd.emit_entry ? char_q_r : raw_r[0];
      out_last_r <= cmd.emit_entry ? sts.entry_last : sts.raw_last;
    end
  end

  // table memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.accept && req == REQ_WR_CHAR && pos_ok) begin
      char_mem[wr_addr] <= b;
    end
    if (cmd.accept && req == REQ_WR_LEN) begin
      len_mem[in_item.entry_index] <= sat_len;
    end
    char_q_r    <= char_mem[rd_addr];
    len_q_r     <= len_mem[code_nxt];
    len_vld_q_r <= len_vld_r[code_nxt];
  end

  assign in_item.ready    = cmd.in_ready;
  assign out_res.valid    = out_valid_r;
  assign out_res.out_byte = out_byte_r;
  assign out_res.last     = out_last_r;

  assign sts.in_valid   = in_item.valid;
  assign sts.act        = dec_act;
  assign sts.len_zero   = (eff_len == '0);
  assign sts.entry_last = (LEN_W'(pos_r) + LEN_W'(1)) == eff_len;
  assign sts.raw_last   = (raw_cnt_r == RAW_CNT_W'(1));
  assign sts.out_free   = !out_valid_r || out_res.ready;

endmodule

// ===== hw/rtl/ctre_ctrl.sv =====
// Controller: sequences accept, table string emission and raw byte emission.
// Depends on ctre_pkg.
module ctre_ctrl import ctre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ctre_sts_t sts,
  output ctre_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        // hold input closed while reset is applied
        cmd.in_ready = rst_n;
        cmd.accept   = sts.in_valid && rst_n;
        if (sts.in_valid && rst_n) begin
          case (sts.act)
            ACT_ENTRY: state_nxt = ST_ENTRY;
            ACT_RAW:   state_nxt = ST_RAW;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ENTRY: begin
        if (sts.len_zero) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_entry = 1'b1;
          if (sts.entry_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RAW: begin
        if (sts.out_free) begin
          cmd.emit_raw = 1'b1;
          if (sts.raw_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/charset_transcoder_rtf_escapes_core.sv =====
// Top level of the charset transcoder with RTF hex escapes.
// Depends on ctre_pkg, ctre_stream_if, ctre_datapath, ctre_ctrl and assert_macros.svh.

// Byte-stream transcoder. Each data word is replaced by the string held in a loaded
// table (0 to MAX_STR bytes per code); in RTF mode backslash-quote-hex-hex escapes are
// decoded first and malformed escapes pass through raw; strip mode clears bit 7; an
// end-of-stream word flushes escape bytes still held. Table writes, end of stream with
// nothing held, and RTF bytes that only advance the parser emit nothing; a word that
// emits raw bytes sends them one by one from the raw queue, and a table lookup sends
// its entry, or nothing when the entry is empty. The single read port of the string
// memory delivers one byte per cycle while the output register is free, and the
// lookup is issued in the cycle in which the word is taken. Results leave through
// a one-word output register, so a stalled sink holds emission but never loses a byte.
// No clearing pass is needed after reset: entry lengths carry per-code valid bits.
`include "assert_macros.svh"

module charset_transcoder_rtf_escapes_core import ctre_pkg::*; #(
  parameter int MAX_STR = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  ctre_in_if.sink    in_item,
  ctre_out_if.source out_res
);

  // command and status between controller and datapath
  ctre_cmd_t cmd;
  ctre_sts_t sts;

  // datapath: parser, table memories, raw queue, output register
  ctre_datapath #(
    .MAX_STR (MAX_STR)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_res   (out_res),
    .cmd       (cmd),
    .sts       (sts)
  );

  // controller: hold input while a word's bytes drain, advance one byte per free slot
  ctre_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // table writes never produce output, so input must reopen the next cycle
  `CTRE_ASSERT(a_wr_reopens, clk, rst_n, in_item.valid && in_item.ready && (in_item.req_type == REQ_WR_CHAR || in_item.req_type == REQ_WR_LEN) |=> in_item.ready, "table write did not return to idle")

  // never load the output register over a word the sink has not taken
  `CTRE_ASSERT(a_emit_free, clk, rst_n, (cmd.emit_entry || cmd.emit_raw) |-> sts.out_free, "output word overwritten")

  // taking a word and emitting a byte are exclusive phases
  `CTRE_ASSERT(a_cmd_excl, clk, rst_n, $onehot0({cmd.accept, cmd.emit_entry, cmd.emit_raw}), "overlapping commands")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for charset_transcoder_rtf_escapes_core.
// Uses ctre_pkg and the ctre_in_if / ctre_out_if stream interfaces from the RTL.
// Predicts every output byte in step with accepted words and checks them in order.
module tb;
  import ctre_pkg::*;

  localparam int MAX_STR       = 16;
  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 9;
  // Wait long enough for the longest lookup of MAX_STR bytes; leave some margin.
  localparam int SETTLE_CYCLES = MAX_STR + 4;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int RUN_LIMIT     = 2000000;
  localparam int PHASE_WORDS   = 30;
  // conversion_mode code with no meaning of its own; it must behave as plain
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  // One input word, all fields at the widths of the input channel.
  typedef struct {
    req_t       req;
    logic [7:0] value;
    logic [7:0] index;
    logic [3:0] pos;
    logic [4:0] len;
  } word_t;

  // One expected output byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_wdata;

  ctre_in_if  in_ch ();
  ctre_out_if out_ch ();

  charset_transcoder_rtf_escapes_core #(
    .MAX_STR(MAX_STR)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_ch),
    .out_res  (out_ch)
  );

  // Shadow copy of the block: translation table, escape parser and mode.
  logic [7:0] map_chars   [CODE_COUNT][MAX_STR];
  logic       char_loaded [CODE_COUNT][MAX_STR];
  logic [4:0] map_len     [CODE_COUNT];
  phase_t     esc_phase;
  logic [7:0] held_char;
  logic [1:0] mode_reg;

  out_word_t  burst[$];          // bytes caused by the word being predicted
  out_word_t  pending_bytes[$];  // bytes predicted but not yet seen
  logic [7:0] live_codes[$];     // codes that were given a non-empty entry

  int  mismatch_count;
  int  words_sent;
  bit  calm;                     // set for the final phase: no idling either side
  int  stall_left;

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] b);
    // Drop anything beyond the per-word result cap.
    if (burst.size() < RESULT_CAP) begin
      burst.push_back('{data: b, last: 1'b0});
    end
  endfunction

  function automatic void push_entry(input logic [7:0] code);
    for (int i = 0; i < map_len[code]; i++) begin
      push_byte(map_chars[code][i]);
    end
  endfunction

  function automatic logic hex_value(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin        // 0..9
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin        // A..F
      v = 4'(c - 8'h41 + 8'd10);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin        // a..f
      v = 4'(c - 8'h61 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void parse_rtf(input logic [7:0] b);
    logic [3:0] hi;
    logic [3:0] lo;
    case (esc_phase)
      PH_IDLE: begin
        if (b == CH_BSLASH) begin
          esc_phase = PH_BSLASH;
        end else begin
          push_entry(b);
        end
      end
      PH_BSLASH: begin
        if (b == CH_QUOTE) begin
          esc_phase = PH_QUOTE;
        end else begin
          // Backslash not followed by a quote: pass both through raw.
          push_byte(CH_BSLASH);
          push_byte(b);
          esc_phase = PH_IDLE;
        end
      end
      PH_QUOTE: begin
        held_char = b;
        esc_phase = PH_HIGH;
      end
      default: begin
        if (hex_value(held_char, hi) && hex_value(b, lo)) begin
          push_entry({hi, lo});
        end else begin
          // Malformed escape: emit all four bytes raw.
          push_byte(CH_BSLASH);
          push_byte(CH_QUOTE);
          push_byte(held_char);
          push_byte(b);
        end
        held_char = '0;
        esc_phase = PH_IDLE;
      end
    endcase
  endfunction

  // Work out the bytes one accepted word causes and queue them.
  function automatic void transcode_word(input word_t w);
    burst.delete();
    case (w.req)
      REQ_DATA: begin
        if (mode_reg == MODE_RTF) begin
          parse_rtf(w.value);
        end else if (mode_reg == MODE_STRIP) begin
          push_byte(w.value & STRIP_MASK);
        end else begin
          push_entry(w.value);
        end
      end
      REQ_WR_CHAR: begin
        if (w.pos < MAX_STR) begin
          map_chars[w.index][w.pos]   = w.value;
          char_loaded[w.index][w.pos] = 1'b1;
        end
      end
      REQ_WR_LEN: begin
        map_len[w.index] = (w.len > MAX_STR) ? 5'(MAX_STR) : w.len;
      end
      default: begin
        // End of stream flushes whatever the parser holds, in any mode.
        if (esc_phase != PH_IDLE) push_byte(CH_BSLASH);
        if (esc_phase == PH_QUOTE || esc_phase == PH_HIGH) push_byte(CH_QUOTE);
        if (esc_phase == PH_HIGH) push_byte(held_char);
        esc_phase = PH_IDLE;
        held_char = '0;
      end
    endcase
    if (burst.size() > 0) begin
      burst[burst.size() - 1].last = 1'b1;
    end
    foreach (burst[i]) begin
      pending_bytes.push_back(burst[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Compare every accepted output byte against the oldest prediction.
  always @(posedge clk) begin : check_output
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  out_ch.out_byte, out_ch.last));
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.out_byte !== want.data) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_ch.out_byte, want.data));
        end
        if (out_ch.last !== want.last) begin
          report_mismatch($sformatf("last %0b on byte %02h, expected %0b",
                                    out_ch.last, out_ch.out_byte, want.last));
        end
      end
    end
  end

  // Sink side: stall in random bursts, never in the final phase.
  always @(negedge clk) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13);
    end
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; every task is entered and left at a falling edge
  // ---------------------------------------------------------------------------

  function automatic word_t random_word();
    word_t w;
    w.req   = req_t'($urandom_range(0, 3));
    w.value = 8'($urandom_range(0, 255));
    w.index = 8'($urandom_range(0, 255));
    w.pos   = 4'($urandom_range(0, 15));
    w.len   = 5'($urandom_range(0, 31));
    return w;
  endfunction

  // Present one word, hold it until taken, and predict it on acceptance.
  task automatic send_word(input word_t w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.req_type     = w.req;
    in_ch.byte_value   = w.value;
    in_ch.entry_index  = w.index;
    in_ch.char_pos     = w.pos;
    in_ch.entry_length = w.len;
    in_ch.valid        = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    transcode_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_data(input logic [7:0] b);
    word_t w;
    w = random_word();
    w.req = REQ_DATA;
    w.value = b;
    send_word(w);
  endtask

  task automatic send_eos();
    word_t w;
    w = random_word();
    w.req = REQ_EOS;
    send_word(w);
  endtask

  // Fill every missing character below the length before writing the length,
  // so that no lookup ever reaches a character that was never written.
  task automatic load_entry(input logic [7:0] code, input logic [4:0] len);
    word_t w;
    int    top;
    top = (len > MAX_STR) ? MAX_STR : len;
    for (int p = 0; p < top; p++) begin
      if (!char_loaded[code][p]) begin
        w = random_word();
        w.req = REQ_WR_CHAR;
        w.index = code;
        w.pos = 4'(p);
        send_word(w);
      end
    end
    w = random_word();
    w.req = REQ_WR_LEN;
    w.index = code;
    w.len = len;
    send_word(w);
    if (top > 0) live_codes.push_back(code);
  endtask

  // Mostly short entries, now and then empty, long or over-long.
  function automatic logic [4:0] random_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 5'd0;
    if (r < 12) return 5'($urandom_range(1, 3));
    if (r < 17) return 5'($urandom_range(4, 16));
    return 5'($urandom_range(17, 31));
  endfunction

  function automatic logic [7:0] pick_code();
    if (live_codes.size() > 0 && $urandom_range(0, 4) != 0) begin
      return live_codes[$urandom_range(0, live_codes.size() - 1)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 10) return 8'h30 + v;
    return (upper ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  task automatic send_escape(input logic [7:0] code);
    send_data(CH_BSLASH);
    send_data(CH_QUOTE);
    send_data(hex_char(code[7:4], 1'($urandom_range(0, 1))));
    send_data(hex_char(code[3:0], 1'($urandom_range(0, 1))));
  endtask

  // Drop valid and wait for every predicted byte to leave the block.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
  endtask

  // Change the mode only with the block idle.
  task automatic set_mode(input logic [1:0] m);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata = m;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    mode_reg  = m;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Load one full entry through an over-long length, which must saturate.
  task automatic test_table_load();
    load_entry(8'h41, 5'd31);
  endtask

  // Plain lookup: full entry, empty entry, end of stream with nothing held.
  task automatic test_plain_mode();
    send_data(8'h41);
    send_data(8'hFF);
    send_eos();
  endtask

  // Strip clears bit 7 only; the unused mode code translates like plain.
  task automatic test_other_modes();
    set_mode(MODE_STRIP);
    send_data(8'hC1);
    send_data(8'h7F);
    set_mode(MODE_UNDEF);
    send_data(8'h41);
  endtask

  task automatic test_rtf_escapes();
    set_mode(MODE_RTF);
    // valid escape for code 41
    send_data(CH_BSLASH);
    send_data(CH_QUOTE);
    send_data(8'h34);
    send_data(8'h31);
    // bad low digit: four bytes raw
    send_data(CH_BSLASH);
    send_data(CH_QUOTE);
    send_data(8'h34);
    send_data(8'h7A);
    // backslash followed by a plain letter
    send_data(CH_BSLASH);
    send_data(8'h78);
    // end of stream with the high digit held
    send_data(CH_BSLASH);
    send_data(CH_QUOTE);
    send_data(8'h34);
    send_eos();
  endtask

  // Parser state must survive a detour through plain mode.
  task automatic test_mode_switch_mid_escape();
    send_data(CH_BSLASH);
    send_data(CH_QUOTE);
    set_mode(MODE_PLAIN);
    send_data(8'h41);
    set_mode(MODE_RTF);
    send_data(8'h34);
    send_data(8'h31);
  endtask

  // One random phase in a given mode.
  task automatic run_traffic(input logic [1:0] m, input int count);
    word_t w;
    int    stop_at;
    int    sel;
    set_mode(m);
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        if ($urandom_range(0, 2) == 0) begin
          // overwrite any character; lengths alone decide what is read
          w = random_word();
          w.req = REQ_WR_CHAR;
          send_word(w);
        end else begin
          load_entry(8'($urandom_range(0, 255)), random_len());
        end
      end else if (sel < 10) begin
        // hold off the sender until everything predicted has come out
        wait_drained();
      end else if (sel < 15) begin
        send_eos();
      end else if (m == MODE_RTF) begin
        if (sel < 55) begin
          send_escape(pick_code());
        end else if (sel < 63) begin
          send_data(CH_BSLASH);
          if ($urandom_range(0, 1) == 0) begin
            send_data(8'($urandom_range(0, 255)));
          end else begin
            send_data(CH_QUOTE);
            send_data(8'($urandom_range(0, 255)));
            send_data(8'($urandom_range(0, 255)));
          end
        end else if (sel < 70) begin
          // cut an escape short with end of stream
          send_data(CH_BSLASH);
          if ($urandom_range(0, 2) != 0) send_data(CH_QUOTE);
          if ($urandom_range(0, 1) != 0) send_data(hex_char(4'($urandom_range(0, 15)), 1'b1));
          send_eos();
        end else if (sel < 90) begin
          send_data(pick_code());
        end else begin
          send_data(8'($urandom_range(0, 255)));
        end
      end else begin
        send_data(sel < 75 ? pick_code() : 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_random_traffic();
    repeat (6) load_entry(8'($urandom_range(0, 255)), random_len());
    run_traffic(MODE_RTF, PHASE_WORDS);
    run_traffic(MODE_PLAIN, PHASE_WORDS);
    run_traffic(MODE_STRIP, PHASE_WORDS);
    run_traffic(MODE_RTF, PHASE_WORDS);
    run_traffic(MODE_UNDEF, PHASE_WORDS);
    // final phase at full rate on both sides
    calm = 1'b1;
    run_traffic(MODE_RTF, PHASE_WORDS);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int spin;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = MODE_PLAIN;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_DATA;
    in_ch.byte_value = '0;
    in_ch.entry_index = '0;
    in_ch.char_pos = '0;
    in_ch.entry_length = '0;
    mismatch_count = 0;
    words_sent = 0;
    calm = 1'b0;
    esc_phase = PH_IDLE;
    held_char = '0;
    mode_reg = MODE_PLAIN;
    foreach (map_len[c]) map_len[c] = '0;
    foreach (char_loaded[c, p]) char_loaded[c][p] = 1'b0;
    foreach (map_chars[c, p]) map_chars[c][p] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_table_load();
    test_plain_mode();
    test_other_modes();
    test_rtf_escapes();
    test_mode_switch_mid_escape();
    test_random_traffic();

    // Let the last bytes out, then allow the block's own latency.
    in_ch.valid = 1'b0;
    for (spin = 0; spin < DRAIN_LIMIT && pending_bytes.size() != 0; spin++) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d predicted bytes never came out", pending_bytes.size()));
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule
